// ===== hw/rtl/nll_pkg.sv =====
`default_nettype none
package nll_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int MAX_RADIX = 36;

   typedef enum logic [4:0] {
      PH_START     = 5'd0,
      PH_SIGN      = 5'd1,
      PH_LEAD      = 5'd2,
      PH_BASED     = 5'd3,
      PH_CODE      = 5'd4,
      PH_ESC       = 5'd5,
      PH_UTF       = 5'd6,
      PH_CODE_DONE = 5'd7,
      PH_DENOM     = 5'd8,
      PH_FRAC      = 5'd9,
      PH_FRAC_S0   = 5'd10,
      PH_FRAC_INF  = 5'd11,
      PH_FRAC_NAN  = 5'd12,
      PH_EXP_SIGN  = 5'd13,
      PH_EXP       = 5'd14,
      PH_INF       = 5'd15,
      PH_NAN       = 5'd16,
      PH_ERR       = 5'd17
   } phase_type;

   typedef enum logic [2:0] {
      KIND_INVALID  = 3'd0,
      KIND_INTEGER  = 3'd1,
      KIND_FLOAT    = 3'd2,
      KIND_RATIONAL = 3'd3,
      KIND_POS_INF  = 3'd4,
      KIND_NEG_INF  = 3'd5,
      KIND_NAN      = 3'd6,
      KIND_RANGE    = 3'd7
   } kind_type;

   // Token state apart from the two value accumulators.
   typedef struct packed {
      phase_type   phase;
      logic        negative;
      logic [5:0]  radix;
      logic [2:0]  digit_flags;
      logic [20:0] utf_acc;
      logic [3:0]  byte_count;
      logic        overflowed;
      logic        is_float;
      logic        plus_sign;
   } ctl_type;

   localparam ctl_type CTL_CLEAR = '{
      phase: PH_START, negative: 1'b0, radix: 6'd10, digit_flags: 3'd0,
      utf_acc: 21'd0, byte_count: 4'd0, overflowed: 1'b0, is_float: 1'b0,
      plus_sign: 1'b0
   };

   // Returns {valid, digit value}.
   function automatic logic [6:0] digit_of(input logic [7:0] b);
      logic [6:0] r;
      r = 7'd0;
      if (b >= "0" && b <= "9") r = {1'b1, 6'(b - "0")};
      else if (b >= "a" && b <= "z") r = {1'b1, 6'(b - "a" + 8'd10)};
      else if (b >= "A" && b <= "Z") r = {1'b1, 6'(b - "A" + 8'd10)};
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nll_if.sv =====
`default_nettype none
interface nll_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       token_end;
   modport source (output valid, text_byte, token_end, input ready);
   modport sink (input valid, text_byte, token_end, output ready);
endinterface

interface nll_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [63:0] int_result;
   logic [62:0] denominator;
   modport source (output valid, kind, int_result, denominator, input ready);
   modport sink (input valid, kind, int_result, denominator, output ready);
endinterface

interface nll_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/nll_step.sv =====
`default_nettype none
// Next-state and result logic for one token byte.
module nll_step #(
   parameter int VALUE_BITS = nll_pkg::VALUE_BITS_DEFAULT
) (
   input  wire nll_pkg::ctl_type  st,
   input  wire [VALUE_BITS-1:0]   mag,
   input  wire [VALUE_BITS-1:0]   den,
   input  wire [7:0]              b,
   input  wire                    ext,
   input  wire                    last,
   output nll_pkg::ctl_type       nst,
   output logic [VALUE_BITS-1:0]  nmag,
   output logic [VALUE_BITS-1:0]  nden,
   output nll_pkg::kind_type      kind,
   output logic [63:0]            int_result,
   output logic [62:0]            denominator
);
   localparam int PW = VALUE_BITS + 7;
   localparam logic [PW-1:0] LIMIT_P = PW'(1) << (VALUE_BITS - 1);
   localparam logic [63:0] LIMIT_64 = 64'(1) << (VALUE_BITS - 1);

   nll_pkg::ctl_type s;
   logic [6:0]       dig;
   logic [5:0]       base;
   logic [VALUE_BITS-1:0] acc_src;
   logic [PW-1:0]    prod;
   logic [VALUE_BITS-1:0] acc_new;
   logic             acc_ovf;
   logic             clean;
   logic             lone_zero;
   logic [20:0]      utf_next;
   logic [3:0]       cnt_next;
   logic [7:0]       tail;
   logic [63:0]      emag;
   logic             emit;
   logic             in_range;

   always_comb begin
      dig = nll_pkg::digit_of(b);
      base = (st.phase == nll_pkg::PH_BASED) ? st.radix : 6'd10;
      acc_src = (st.phase == nll_pkg::PH_DENOM) ? den : mag;
      prod = PW'(acc_src) * PW'(base) + PW'(dig[5:0]);
      acc_ovf = prod > LIMIT_P;
      acc_new = prod[VALUE_BITS-1:0];
      clean = !st.digit_flags[2];
      lone_zero = st.byte_count == 4'd1 && mag == '0 && clean;
      utf_next = {st.utf_acc[14:0], b[5:0]};
      cnt_next = st.byte_count - 4'd1;
      if (st.phase == nll_pkg::PH_INF) tail = (st.byte_count == 4'd0) ? "n" : "f";
      else tail = (st.byte_count == 4'd0) ? "a" : "N";

      s = st;
      nmag = mag;
      nden = den;
      if (b == 8'd0) begin
         s.phase = nll_pkg::PH_ERR;
      end else begin
         unique case (st.phase)
            nll_pkg::PH_START, nll_pkg::PH_SIGN: begin
               if (st.phase == nll_pkg::PH_START && (b == "+" || b == "-")) begin
                  s.plus_sign = b == "+";
                  s.negative = b == "-";
                  s.phase = nll_pkg::PH_SIGN;
               end else if (b >= "0" && b <= "9") begin
                  s.phase = nll_pkg::PH_LEAD;
                  s.digit_flags = 3'd1;
                  s.byte_count = 4'd1;
                  nmag = VALUE_BITS'(b - "0");
               end else begin
                  s.phase = nll_pkg::PH_ERR;
               end
            end
            nll_pkg::PH_CODE: begin
               if (b == "\\") begin
                  s.phase = nll_pkg::PH_ESC;
               end else if (b < 8'h80) begin
                  s.utf_acc = 21'(b);
                  s.phase = nll_pkg::PH_CODE_DONE;
               end else if (b >= 8'hc2 && b <= 8'hdf) begin
                  s.utf_acc = 21'(b[4:0]);
                  s.radix = 6'd2;
                  s.byte_count = 4'd1;
                  s.phase = nll_pkg::PH_UTF;
               end else if (b >= 8'he0 && b <= 8'hef) begin
                  s.utf_acc = 21'(b[3:0]);
                  s.radix = 6'd3;
                  s.byte_count = 4'd2;
                  s.phase = nll_pkg::PH_UTF;
               end else if (b >= 8'hf0 && b <= 8'hf4) begin
                  s.utf_acc = 21'(b[2:0]);
                  s.radix = 6'd4;
                  s.byte_count = 4'd3;
                  s.phase = nll_pkg::PH_UTF;
               end else begin
                  s.phase = nll_pkg::PH_ERR;
               end
            end
            nll_pkg::PH_ESC: begin
               s.phase = nll_pkg::PH_CODE_DONE;
               unique case (b)
                  "n":  s.utf_acc = 21'd10;
                  "r":  s.utf_acc = 21'd13;
                  "t":  s.utf_acc = 21'd9;
                  "\\": s.utf_acc = 21'd92;
                  "'":  s.utf_acc = 21'd39;
                  "\"": s.utf_acc = 21'd34;
                  default: s.phase = nll_pkg::PH_ERR;
               endcase
            end
            nll_pkg::PH_UTF: begin
               if (b[7:6] != 2'b10 || st.byte_count == 4'd0) begin
                  s.phase = nll_pkg::PH_ERR;
               end else begin
                  s.utf_acc = utf_next;
                  s.byte_count = cnt_next;
                  if (cnt_next == 4'd0) begin
                     if ((st.radix == 6'd3 && utf_next < 21'h800) ||
                         (st.radix == 6'd4 && utf_next < 21'h10000) ||
                         (utf_next >= 21'hd800 && utf_next <= 21'hdfff) ||
                         utf_next > 21'h10ffff)
                        s.phase = nll_pkg::PH_ERR;
                     else
                        s.phase = nll_pkg::PH_CODE_DONE;
                  end
               end
            end
            nll_pkg::PH_EXP_SIGN: begin
               if (b == "+" || b == "-") begin
                  s.digit_flags = 3'd0;
                  s.phase = nll_pkg::PH_EXP;
               end else if (b >= "0" && b <= "9") begin
                  s.digit_flags = 3'd1;
                  s.phase = nll_pkg::PH_EXP;
               end else begin
                  s.phase = nll_pkg::PH_ERR;
               end
            end
            nll_pkg::PH_INF, nll_pkg::PH_NAN: begin
               if (st.byte_count < 4'd2 && b == tail) s.byte_count = st.byte_count + 4'd1;
               else s.phase = nll_pkg::PH_ERR;
            end
            nll_pkg::PH_LEAD, nll_pkg::PH_BASED, nll_pkg::PH_DENOM, nll_pkg::PH_FRAC,
            nll_pkg::PH_FRAC_S0, nll_pkg::PH_FRAC_INF, nll_pkg::PH_FRAC_NAN,
            nll_pkg::PH_EXP: begin
               if (st.phase == nll_pkg::PH_FRAC_INF && b == "I") begin
                  s.byte_count = 4'd0;
                  s.phase = nll_pkg::PH_INF;
               end else if (st.phase == nll_pkg::PH_FRAC_NAN && b == "N") begin
                  s.byte_count = 4'd0;
                  s.phase = st.plus_sign ? nll_pkg::PH_ERR : nll_pkg::PH_NAN;
               end else if (dig[6] && dig[5:0] < base) begin
                  s.digit_flags = {st.digit_flags[2], 2'b01};
                  if (st.phase == nll_pkg::PH_LEAD || st.phase == nll_pkg::PH_BASED ||
                      st.phase == nll_pkg::PH_DENOM) begin
                     if (!st.overflowed) begin
                        if (acc_ovf) s.overflowed = 1'b1;
                        else if (st.phase == nll_pkg::PH_DENOM) nden = acc_new;
                        else nmag = acc_new;
                     end
                     if (st.phase == nll_pkg::PH_LEAD && st.byte_count < 4'd15)
                        s.byte_count = st.byte_count + 4'd1;
                  end else if (st.phase == nll_pkg::PH_FRAC_S0) begin
                     if (dig[5:0] == 6'd0) s.phase = nll_pkg::PH_FRAC_INF;
                     else if (dig[5:0] == 6'd5) s.phase = nll_pkg::PH_FRAC_NAN;
                     else s.phase = nll_pkg::PH_FRAC;
                  end else if (st.phase == nll_pkg::PH_FRAC_INF ||
                               st.phase == nll_pkg::PH_FRAC_NAN) begin
                     s.phase = nll_pkg::PH_FRAC;
                  end
               end else if (b == "_" && ext && st.digit_flags[0]) begin
                  s.digit_flags = {st.digit_flags[2] | (st.phase == nll_pkg::PH_LEAD), 2'b10};
                  if (st.phase == nll_pkg::PH_FRAC_S0 || st.phase == nll_pkg::PH_FRAC_INF ||
                      st.phase == nll_pkg::PH_FRAC_NAN)
                     s.phase = nll_pkg::PH_FRAC;
               end else if (!st.digit_flags[0]) begin
                  s.phase = nll_pkg::PH_ERR;
               end else if (st.phase == nll_pkg::PH_LEAD) begin
                  if (ext && lone_zero && (b == "x" || b == "X" || b == "o" || b == "O" ||
                                           b == "b" || b == "B")) begin
                     s.radix = (b == "x" || b == "X") ? 6'd16 :
                               ((b == "o" || b == "O") ? 6'd8 : 6'd2);
                     s.digit_flags = 3'd0;
                     s.phase = nll_pkg::PH_BASED;
                  end else if (ext && b == "'" && clean && !st.overflowed &&
                               mag <= VALUE_BITS'(nll_pkg::MAX_RADIX)) begin
                     if (mag == '0) begin
                        s.phase = nll_pkg::PH_CODE;
                     end else if (mag >= VALUE_BITS'(2)) begin
                        s.radix = mag[5:0];
                        nmag = '0;
                        s.digit_flags = 3'd0;
                        s.phase = nll_pkg::PH_BASED;
                     end else begin
                        s.phase = nll_pkg::PH_ERR;
                     end
                  end else if (ext && b == "r") begin
                     s.digit_flags = 3'd0;
                     s.phase = nll_pkg::PH_DENOM;
                  end else if (b == ".") begin
                     s.is_float = 1'b1;
                     s.digit_flags = 3'd0;
                     s.phase = (ext && clean && st.byte_count == 4'd1 && mag == VALUE_BITS'(1))
                               ? nll_pkg::PH_FRAC_S0 : nll_pkg::PH_FRAC;
                  end else if (b == "e" || b == "E") begin
                     s.is_float = 1'b1;
                     s.digit_flags = 3'd0;
                     s.phase = nll_pkg::PH_EXP_SIGN;
                  end else begin
                     s.phase = nll_pkg::PH_ERR;
                  end
               end else if ((st.phase == nll_pkg::PH_FRAC || st.phase == nll_pkg::PH_FRAC_S0 ||
                             st.phase == nll_pkg::PH_FRAC_INF ||
                             st.phase == nll_pkg::PH_FRAC_NAN) && (b == "e" || b == "E")) begin
                  s.digit_flags = 3'd0;
                  s.phase = nll_pkg::PH_EXP_SIGN;
               end else begin
                  s.phase = nll_pkg::PH_ERR;
               end
            end
            default: s.phase = nll_pkg::PH_ERR;
         endcase
      end

      // Classification on the state after this byte.
      kind = nll_pkg::KIND_INVALID;
      int_result = 64'd0;
      denominator = 63'd0;
      emit = 1'b0;
      emag = 64'(nmag);
      unique case (s.phase)
         nll_pkg::PH_LEAD, nll_pkg::PH_BASED: emit = s.digit_flags[0];
         nll_pkg::PH_CODE_DONE: begin
            emit = 1'b1;
            emag = 64'(s.utf_acc);
         end
         nll_pkg::PH_ESC: begin
            emit = 1'b1;
            emag = 64'd92;
         end
         default: emit = 1'b0;
      endcase
      in_range = !s.overflowed && emag <= (s.negative ? LIMIT_64 : LIMIT_64 - 64'd1);
      if (emit) begin
         if (in_range) begin
            kind = nll_pkg::KIND_INTEGER;
            int_result = s.negative ? 64'd0 - emag : emag;
         end else begin
            kind = nll_pkg::KIND_RANGE;
         end
      end else if (s.phase == nll_pkg::PH_DENOM) begin
         if (s.digit_flags[0]) begin
            if (!in_range || 64'(nden) > LIMIT_64 - 64'd1) begin
               kind = nll_pkg::KIND_RANGE;
            end else begin
               kind = nll_pkg::KIND_RATIONAL;
               int_result = s.negative ? 64'd0 - emag : emag;
               denominator = 63'(nden);
            end
         end
      end else if (s.phase == nll_pkg::PH_FRAC || s.phase == nll_pkg::PH_FRAC_S0 ||
                   s.phase == nll_pkg::PH_FRAC_INF || s.phase == nll_pkg::PH_FRAC_NAN ||
                   s.phase == nll_pkg::PH_EXP) begin
         if (s.digit_flags[0] && s.is_float) kind = nll_pkg::KIND_FLOAT;
      end else if (s.phase == nll_pkg::PH_INF) begin
         if (s.byte_count == 4'd2)
            kind = s.negative ? nll_pkg::KIND_NEG_INF : nll_pkg::KIND_POS_INF;
      end else if (s.phase == nll_pkg::PH_NAN) begin
         if (s.byte_count == 4'd2) kind = nll_pkg::KIND_NAN;
      end

      nst = s;
      if (last) begin
         nst = nll_pkg::CTL_CLEAR;
         nmag = '0;
         nden = '0;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/numeric_literal_lexer.sv =====
`default_nettype none
// Flow: a byte transfer is registered in the input stage, then classified by the step logic;
//   the result of a final byte is registered in the result register and held until taken.
// Throughput: one byte per cycle via the combinational multiply-add; a final byte may stall.
// Reset: synchronous, active high; clears the token state and both channel stages and sets
//   the extended grammar register to one.
module numeric_literal_lexer #(
   parameter int VALUE_BITS = nll_pkg::VALUE_BITS_DEFAULT
) (
   input wire         clock,
   input wire         reset,
   nll_req_if.sink    req_chan,
   nll_rsp_if.source  rsp_chan,
   nll_csr_if.sink    csr_chan
);
   // Input stage: holds one byte transfer until the step logic consumes it.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // Token state.
   nll_pkg::ctl_type      ctl_ff, ctl_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic                  ext_ff;

   // Result register.
   logic        out_valid_ff;
   logic [2:0]  out_kind_ff;
   logic [63:0] out_int_ff;
   logic [62:0] out_den_ff;

   nll_pkg::kind_type step_kind;
   logic [63:0]       step_int;
   logic [62:0]       step_den;
   logic              out_free;
   logic              step_fire;

   // A non-final byte never needs the result register, so only a final byte can stall.
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign step_fire = in_valid_ff && (!in_end_ff || out_free);
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign csr_chan.ready = 1'b1;

   nll_step #(.VALUE_BITS(VALUE_BITS)) u_step (
      .st          (ctl_ff),
      .mag         (mag_ff),
      .den         (den_ff),
      .b           (in_byte_ff),
      .ext         (ext_ff),
      .last        (in_end_ff),
      .nst         (ctl_in),
      .nmag        (mag_in),
      .nden        (den_in),
      .kind        (step_kind),
      .int_result  (step_int),
      .denominator (step_den)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff       <= nll_pkg::CTL_CLEAR;
         mag_ff       <= '0;
         den_ff       <= '0;
         ext_ff       <= 1'b1;
      end else begin
         if (csr_chan.valid) ext_ff <= csr_chan.data;
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_chan.text_byte;
            in_end_ff   <= req_chan.token_end;
         end else if (step_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (step_fire) begin
            ctl_ff <= ctl_in;
            mag_ff <= mag_in;
            den_ff <= den_in;
         end
         // The result register loads on a final byte and empties when its transfer completes.
         if (step_fire && in_end_ff) begin
            out_valid_ff <= 1'b1;
            out_kind_ff  <= step_kind;
            out_int_ff   <= step_int;
            out_den_ff   <= step_den;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_kind_ff;
   assign rsp_chan.int_result  = out_int_ff;
   assign rsp_chan.denominator = out_den_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> ctl_ff.phase == nll_pkg::PH_START)
      else $error("token state not cleared by reset");
   a_final_loads: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_end_ff |=> out_valid_ff)
      else $error("final byte produced no result");
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_end_ff |=> ctl_ff.phase == nll_pkg::PH_START && mag_ff == '0)
      else $error("token state not cleared after final byte");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !(step_fire && in_end_ff))
      else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire
